>>> sv/tcw_pkg.sv
// Shared types, constants and codes for the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths of the request and response
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 4;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = 16;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ATTR_W  = 8;

    // Character and cell constants
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CODE_W-1:0] NUL_CODE     = 8'h00;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_RAW   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code;
        logic [COLOR_W-1:0]  fore;
        logic [COLOR_W-1:0]  back;
        logic [IDX_W-1:0]    cell_index;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_data;
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
        logic                scrolled;
    } t_rsp;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_SCROLL,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap;
        logic exec;
        logic sweep_clr;
        logic sweep_scr;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_kind kind;
        logic  will_scroll;
        logic  sweep_last;
    } t_sts;

endpackage

>>> sv/tcw_ctrl.sv
// Controller state machine for the text console writer.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_rsp_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_req_stall,
    output logic o_rsp_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_char;

    assign w_out_free = !r_out_valid || !i_rsp_stall;
    assign w_char     = (i_sts.kind == KIND_TEXT) || (i_sts.kind == KIND_RAW);

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_sts.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                priority if (i_sts.kind == KIND_CLEAR) n_state = ST_CLEAR;
                else if (i_sts.will_scroll)           n_state = ST_SCROLL;
                else if (i_sts.kind == KIND_READ)     n_state = ST_FINISH;
                else if (w_out_free)                  n_state = ST_IDLE;
                else                                  n_state = ST_FINISH;
            end
            ST_CLEAR: begin
                if (i_sts.sweep_last) n_state = ST_FINISH;
            end
            ST_SCROLL: begin
                if (i_sts.sweep_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Drive commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_INIT:   o_cmd.sweep_clr = 1'b1;
            ST_IDLE:   o_cmd.cap       = i_req_valid;
            ST_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.load_out = w_char && !i_sts.will_scroll && w_out_free;
            end
            ST_CLEAR:  o_cmd.sweep_clr = 1'b1;
            ST_SCROLL: o_cmd.sweep_scr = 1'b1;
            ST_FINISH: o_cmd.load_out  = w_out_free;
            default:   o_cmd = '0;
        endcase
    end

    // Hold the response valid until it is taken
    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_rsp_stall);
    assign o_rsp_valid = r_out_valid;
    assign o_req_stall = (r_state != ST_IDLE);

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.cap, o_cmd.exec, o_cmd.sweep_clr, o_cmd.sweep_scr}))
        else $error("controller issued overlapping datapath steps");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_rsp_stall))
        else $error("response loaded over a pending response");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_cmd.exec)
        else $error("accepted request not executed next cycle");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (o_rsp_valid && r_state == ST_IDLE))
        else $error("response load did not finish the request");

endmodule

>>> sv/tcw_dpath.sv
// Datapath for the text console writer: cell store, cursor, sweep counter, response.
module tcw_dpath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_req               i_req,
    input  logic               i_cfg_we,
    input  logic [ATTR_W-1:0]  i_cfg_data,
    output t_sts               o_sts,
    output t_rsp               o_rsp
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int KW         = $clog2(CELL_COUNT + 1);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int XW         = (AW > IDX_W) ? AW : IDX_W;

    logic [CELL_W-1:0] r_cells [CELL_COUNT];
    logic [CELL_W-1:0] r_rd;
    t_req              r_req;
    t_rsp              r_rsp;
    logic [ATTR_W-1:0] r_attr;
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     r_line;
    logic [RW-1:0]     n_line;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     n_pos;
    logic              r_scr;
    logic              n_scr;
    logic [KW-1:0]     r_k;

    logic              w_last_col;
    logic              w_last_line;
    logic              w_is_nl;
    logic              w_is_nul;
    logic              w_put;
    logic              w_will_scroll;
    logic [XW-1:0]     w_idx_x;
    logic              w_in_range;
    logic [KW-1:0]     w_km1;
    logic [KW-1:0]     w_kpc;
    logic              w_sweep_last;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [ATTR_W-1:0] w_attr;
    t_rsp              w_rsp;

    // Decode the held request
    assign w_last_col    = (r_col == CW'(COLUMNS - 1));
    assign w_last_line   = (r_line == RW'(ROWS - 1));
    assign w_is_nl       = (r_req.kind == KIND_TEXT) && (r_req.code == NEWLINE_CODE);
    assign w_is_nul      = (r_req.kind == KIND_TEXT) && (r_req.code == NUL_CODE);
    assign w_put         = ((r_req.kind == KIND_TEXT) && !w_is_nl && !w_is_nul)
                         || (r_req.kind == KIND_RAW);
    assign w_will_scroll = (w_is_nl && w_last_line) || (w_put && w_last_col && w_last_line);
    assign w_idx_x       = XW'(r_req.cell_index);
    assign w_in_range    = (w_idx_x < XW'(CELL_COUNT));
    assign w_attr        = (r_req.kind == KIND_TEXT) ? r_attr : {r_req.back, r_req.fore};

    // Sweep addressing: scroll reads one row ahead and writes one cell behind
    assign w_km1        = r_k - KW'(1);
    assign w_kpc        = r_k + KW'(COLUMNS);
    assign w_sweep_last = i_cmd.sweep_scr ? (r_k == KW'(CELL_COUNT))
                                          : (r_k == KW'(CELL_COUNT - 1));

    // Next cursor
    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        n_pos  = r_pos;
        n_scr  = r_scr;
        if (i_cmd.exec) begin
            n_scr = w_will_scroll;
            if (r_req.kind == KIND_CLEAR) begin
                n_col  = '0;
                n_line = '0;
                n_pos  = '0;
            end else if (w_is_nl) begin
                n_col = '0;
                if (w_last_line) begin
                    n_pos = AW'(LAST_BASE);
                end else begin
                    n_line = r_line + RW'(1);
                    n_pos  = r_pos - AW'(r_col) + AW'(COLUMNS);
                end
            end else if (w_put) begin
                if (w_last_col) begin
                    n_col = '0;
                    if (!w_last_line) n_line = r_line + RW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
                n_pos = w_will_scroll ? AW'(LAST_BASE) : (r_pos + AW'(1));
            end
        end
    end

    // Select the memory ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = w_idx_x[AW-1:0];
        if (i_cmd.exec) begin
            w_we    = w_put;
            w_wdata = {w_attr, r_req.code};
            w_re    = (r_req.kind == KIND_READ) && w_in_range;
        end else if (i_cmd.sweep_clr) begin
            w_we    = 1'b1;
            w_waddr = r_k[AW-1:0];
        end else if (i_cmd.sweep_scr) begin
            w_we    = (r_k != '0);
            w_waddr = w_km1[AW-1:0];
            w_wdata = (w_km1 < KW'(LAST_BASE)) ? r_rd : BLANK_CELL;
            w_re    = (r_k < KW'(LAST_BASE));
            w_raddr = w_kpc[AW-1:0];
        end
    end

    // Cell store
    always_ff @(posedge i_clk) begin
        if (w_we) r_cells[w_waddr] <= w_wdata;
        if (w_re) r_rd <= r_cells[w_raddr];
    end

    // Build the response
    always_comb begin
        w_rsp.cell_data  = ((r_req.kind == KIND_READ) && w_in_range) ? r_rd : '0;
        w_rsp.cursor_col = COL_W'(n_col);
        w_rsp.cursor_row = ROW_W'(n_line);
        w_rsp.scrolled   = n_scr;
    end

    // Hold request and response payloads
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap)      r_req <= i_req;
        if (i_cmd.load_out) r_rsp <= w_rsp;
    end

    // Update cursor, attribute and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
            r_pos  <= '0;
            r_scr  <= 1'b0;
            r_k    <= '0;
            r_attr <= ATTR_RESET;
        end else begin
            r_col  <= n_col;
            r_line <= n_line;
            r_pos  <= n_pos;
            r_scr  <= n_scr;
            if (i_cmd.sweep_clr || i_cmd.sweep_scr) begin
                r_k <= w_sweep_last ? '0 : (r_k + KW'(1));
            end
            if (i_cfg_we) r_attr <= i_cfg_data;
        end
    end

    assign o_sts.kind        = r_req.kind;
    assign o_sts.will_scroll = w_will_scroll;
    assign o_sts.sweep_last  = w_sweep_last;
    assign o_rsp             = r_rsp;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < COLUMNS) && (int'(r_line) < ROWS))
        else $error("cursor left the screen");

    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pos) == int'(r_line) * COLUMNS + int'(r_col))
        else $error("cell position out of step with cursor");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_k) <= CELL_COUNT)
        else $error("sweep counter ran past the store");

endmodule

>>> sv/text_console_writer_core.sv
// Top level of the text console writer.
//
// Request channel: i_req_valid / o_req_stall carry one t_req. Kind text writes
// a character with the configured attribute (newline moves to the next row,
// a zero code is ignored), kind raw writes a character with its own colors,
// kind clear zeroes the store and homes the cursor, kind read returns a cell.
// Response channel: o_rsp_valid / i_rsp_stall carry one t_rsp per request with
// the cursor after the request, the read cell and the scroll flag.
// Config: i_cfg_we / i_cfg_data set the text attribute; write only when idle.
// Request steps: text/raw load the response in ST_EXEC if the response
// register is free, else in ST_FINISH; a read goes through ST_EXEC and
// ST_FINISH; clear and a write that scrolls run an ST_CLEAR or ST_SCROLL
// sweep before ST_FINISH, its length set by the one-write, one-read port of
// the cell store that the sweeps walk one cell per cycle. One request is in work
// at a time; the next is taken once the response is in the output register.
// Reset: cursor homes, attribute goes to 0x0F, then a clearing pass zeroes
// the store while o_req_stall stays high.
// A stalled response holds in the output register; the block finishes the
// next request and waits to deliver it until the register frees.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output t_rsp              o_rsp,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence the request steps
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid)
    );

    // Hold the store, cursor and response
    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sts      (w_sts),
        .o_rsp      (o_rsp)
    );

endmodule
